// ===== hw/rtl/vgmscan_pkg.sv =====
// Shared types, constants and decode tables for the command stream device scanner
package vgmscan_pkg;

   localparam int unsigned DEV_MASK_WIDTH = 43;
   localparam int unsigned VERSION_WIDTH  = 14;
   localparam int unsigned CHIP_WIDTH     = 6;
   localparam int unsigned OPLEN_WIDTH    = 4;
   localparam int unsigned MAX_CHIP       = 42;

   typedef logic [DEV_MASK_WIDTH-1:0] dev_mask_type;
   typedef logic [CHIP_WIDTH-1:0]     chip_type;
   typedef logic [1:0]                end_cause_type;
   typedef logic [2:0]                op_kind_type;

   localparam end_cause_type CAUSE_END_OPCODE = 2'd0;
   localparam end_cause_type CAUSE_UNKNOWN_OP = 2'd1;
   localparam end_cause_type CAUSE_RAN_OUT    = 2'd2;

   localparam op_kind_type KIND_UNKNOWN  = 3'd0;
   localparam op_kind_type KIND_END      = 3'd1;
   localparam op_kind_type KIND_PLAIN    = 3'd2;
   localparam op_kind_type KIND_DUALCHIP = 3'd3;
   localparam op_kind_type KIND_PARAM    = 3'd4;
   localparam op_kind_type KIND_STEREO   = 3'd5;
   localparam op_kind_type KIND_BLOCK    = 3'd6;
   localparam op_kind_type KIND_RAM      = 3'd7;

   localparam logic [7:0] OP_STEREO     = 8'h4f;
   localparam logic [7:0] OP_END        = 8'h66;
   localparam logic [7:0] OP_DATA_BLOCK = 8'h67;
   localparam logic [7:0] OP_RAM_WRITE  = 8'h68;
   localparam logic [7:0] STEREO_OFF    = 8'hff;

   localparam logic [VERSION_WIDTH-1:0] LONG_OPS_VERSION = VERSION_WIDTH'(160);

   typedef struct packed {
      op_kind_type              kind;
      chip_type                 chip;
      logic [OPLEN_WIDTH-1:0]   len;
   } op_decode_type;

   function automatic dev_mask_type chip_bit(input chip_type chip);
      dev_mask_type mask;
      mask = '0;
      if (chip != '0 && chip <= CHIP_WIDTH'(MAX_CHIP)) begin
         mask = dev_mask_type'(1) << chip;
      end
      return mask;
   endfunction

   function automatic chip_type ym_chip(input logic [3:0] lo);
      chip_type chip;
      case (lo)
         4'h1: chip = 6'd2;
         4'h2: chip = 6'd3;
         4'h3: chip = 6'd3;
         4'h4: chip = 6'd4;
         4'h5: chip = 6'd7;
         4'h6: chip = 6'd8;
         4'h7: chip = 6'd8;
         4'h8: chip = 6'd9;
         4'h9: chip = 6'd9;
         4'ha: chip = 6'd10;
         4'hb: chip = 6'd11;
         4'hc: chip = 6'd12;
         4'hd: chip = 6'd16;
         4'he: chip = 6'd13;
         4'hf: chip = 6'd13;
         default: chip = 6'd0;
      endcase
      return chip;
   endfunction

   function automatic chip_type b_param_chip(input logic [3:0] lo);
      chip_type chip;
      case (lo)
         4'h3: chip = 6'd20;
         4'h4: chip = 6'd21;
         4'h5: chip = 6'd22;
         4'h6: chip = 6'd23;
         4'h7: chip = 6'd24;
         4'h8: chip = 6'd25;
         4'h9: chip = 6'd28;
         4'ha: chip = 6'd30;
         4'hb: chip = 6'd31;
         4'hc: chip = 6'd34;
         4'hd: chip = 6'd36;
         4'he: chip = 6'd38;
         4'hf: chip = 6'd41;
         default: chip = 6'd0;
      endcase
      return chip;
   endfunction

   function automatic chip_type c_param_chip(input logic [3:0] lo);
      chip_type chip;
      case (lo)
         4'h3: chip = 6'd22;
         4'h5: chip = 6'd33;
         4'h6: chip = 6'd34;
         4'h7: chip = 6'd35;
         4'h8: chip = 6'd39;
         default: chip = 6'd0;
      endcase
      return chip;
   endfunction

   function automatic chip_type d_param_chip(input logic [3:0] lo);
      chip_type chip;
      case (lo)
         4'h0: chip = 6'd14;
         4'h1: chip = 6'd15;
         4'h3: chip = 6'd27;
         4'h4: chip = 6'd29;
         4'h5: chip = 6'd37;
         4'h6: chip = 6'd38;
         default: chip = 6'd0;
      endcase
      return chip;
   endfunction

   function automatic chip_type stream_chip(input logic [2:0] idx);
      chip_type chip;
      case (idx)
         3'd0: chip = 6'd3;
         3'd1: chip = 6'd6;
         3'd2: chip = 6'd17;
         3'd3: chip = 6'd18;
         3'd4: chip = 6'd24;
         3'd5: chip = 6'd28;
         3'd6: chip = 6'd33;
         3'd7: chip = 6'd21;
         default: chip = 6'd0;
      endcase
      return chip;
   endfunction

   function automatic chip_type dump_chip(input logic [4:0] idx);
      chip_type chip;
      case (idx)
         5'd0:  chip = 6'd5;
         5'd1:  chip = 6'd8;
         5'd2:  chip = 6'd9;
         5'd3:  chip = 6'd9;
         5'd4:  chip = 6'd14;
         5'd5:  chip = 6'd15;
         5'd6:  chip = 6'd16;
         5'd7:  chip = 6'd14;
         5'd8:  chip = 6'd12;
         5'd9:  chip = 6'd22;
         5'd10: chip = 6'd23;
         5'd11: chip = 6'd25;
         5'd12: chip = 6'd27;
         5'd13: chip = 6'd29;
         5'd14: chip = 6'd30;
         5'd15: chip = 6'd32;
         5'd16: chip = 6'd38;
         5'd17: chip = 6'd39;
         5'd18: chip = 6'd40;
         5'd19: chip = 6'd41;
         default: chip = 6'd0;
      endcase
      return chip;
   endfunction

   // Block type byte to chip: stream, compressed stream, dump and RAM write types
   function automatic chip_type block_chip(input logic [7:0] t);
      chip_type chip;
      chip = '0;
      if (!t[7]) begin
         if (t != 8'h7f && t[5:3] == 3'b000) begin
            chip = stream_chip(t[2:0]);
         end
      end else if (!t[6]) begin
         if (!t[5] && t[4:0] < 5'd20) begin
            chip = dump_chip(t[4:0]);
         end
      end else begin
         case (t)
            8'hc0: chip = 6'd6;
            8'hc1: chip = 6'd17;
            8'hc2: chip = 6'd21;
            8'he0: chip = 6'd33;
            8'he1: chip = 6'd37;
            default: chip = 6'd0;
         endcase
      end
      return chip;
   endfunction

   function automatic op_decode_type classify(input logic [7:0] op, input logic long_ops);
      op_decode_type d;
      logic [3:0]    lo;
      lo = op[3:0];
      d.kind = KIND_UNKNOWN;
      d.chip = '0;
      d.len  = '0;
      if (op == OP_END) begin
         d.kind = KIND_END;
      end else if (op == OP_STEREO) begin
         d.kind = KIND_STEREO;
      end else if (op == OP_DATA_BLOCK) begin
         d.kind = KIND_BLOCK;
      end else if (op == OP_RAM_WRITE) begin
         d.kind = KIND_RAM;
      end else if (op >= 8'h30 && op <= 8'h3f) begin
         d.kind = KIND_DUALCHIP; d.chip = 6'd1; d.len = 4'd1;
      end else if (op >= 8'h40 && op <= 8'h4e) begin
         d.kind = KIND_PLAIN; d.len = long_ops ? 4'd2 : 4'd1;
      end else if (op == 8'h50) begin
         d.kind = KIND_PLAIN; d.chip = 6'd1; d.len = 4'd1;
      end else if (op >= 8'h51 && op <= 8'h5f) begin
         d.kind = KIND_PLAIN; d.chip = ym_chip(lo); d.len = 4'd2;
      end else if (op >= 8'ha1 && op <= 8'haf) begin
         d.kind = KIND_DUALCHIP; d.chip = ym_chip(lo); d.len = 4'd2;
      end else if (op == 8'h61) begin
         d.kind = KIND_PLAIN; d.len = 4'd2;
      end else if (op == 8'h62 || op == 8'h63) begin
         d.kind = KIND_PLAIN;
      end else if (op == 8'h64) begin
         d.kind = KIND_PLAIN; d.len = 4'd3;
      end else if (op >= 8'h70 && op <= 8'h7f) begin
         d.kind = KIND_PLAIN;
      end else if (op >= 8'h80 && op <= 8'h8f) begin
         d.kind = KIND_PLAIN; d.chip = 6'd3;
      end else if (op == 8'h90 || op == 8'h91 || op == 8'h95) begin
         d.kind = KIND_PLAIN; d.len = 4'd4;
      end else if (op == 8'h92) begin
         d.kind = KIND_PLAIN; d.len = 4'd5;
      end else if (op == 8'h93) begin
         d.kind = KIND_PLAIN; d.len = 4'd10;
      end else if (op == 8'h94) begin
         d.kind = KIND_PLAIN; d.len = 4'd1;
      end else if (op == 8'ha0) begin
         d.kind = KIND_PARAM; d.chip = 6'd19; d.len = 4'd2;
      end else if (op == 8'hb0) begin
         d.kind = KIND_PLAIN; d.chip = 6'd6; d.len = 4'd2;
      end else if (op == 8'hb1) begin
         d.kind = KIND_PLAIN; d.chip = 6'd17; d.len = 4'd2;
      end else if (op == 8'hb2) begin
         d.kind = KIND_PLAIN; d.chip = 6'd18; d.len = 4'd2;
      end else if (op >= 8'hb3 && op <= 8'hbf) begin
         d.kind = KIND_PARAM; d.chip = b_param_chip(lo); d.len = 4'd2;
      end else if (op == 8'hc0) begin
         d.kind = KIND_PLAIN; d.chip = 6'd5; d.len = 4'd3;
      end else if (op == 8'hc1) begin
         d.kind = KIND_PLAIN; d.chip = 6'd6; d.len = 4'd3;
      end else if (op == 8'hc2) begin
         d.kind = KIND_PLAIN; d.chip = 6'd17; d.len = 4'd3;
      end else if (op == 8'hc4) begin
         d.kind = KIND_PLAIN; d.chip = 6'd32; d.len = 4'd3;
      end else if (op == 8'hc3 || (op >= 8'hc5 && op <= 8'hc8)) begin
         d.kind = KIND_PARAM; d.chip = c_param_chip(lo); d.len = 4'd3;
      end else if (op >= 8'hc9 && op <= 8'hcf) begin
         d.kind = KIND_PLAIN; d.len = 4'd3;
      end else if (op == 8'hd0 || op == 8'hd1 || (op >= 8'hd3 && op <= 8'hd6)) begin
         d.kind = KIND_PARAM; d.chip = d_param_chip(lo); d.len = 4'd3;
      end else if (op == 8'hd2 || (op >= 8'hd7 && op <= 8'hdf)) begin
         d.kind = KIND_PLAIN; d.len = 4'd3;
      end else if (op == 8'he1) begin
         d.kind = KIND_PARAM; d.chip = 6'd40; d.len = 4'd4;
      end else if (op == 8'he0 || op >= 8'he2) begin
         d.kind = KIND_PLAIN; d.len = 4'd4;
      end
      return d;
   endfunction

endpackage

// ===== hw/rtl/vgmscan_if.sv =====
// Valid/ready channel interfaces for the scanner's byte input and result output
interface vgmscan_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface vgmscan_rsp_if;
   logic                        valid;
   logic                        ready;
   vgmscan_pkg::dev_mask_type   single_devices;
   vgmscan_pkg::dev_mask_type   second_devices;
   vgmscan_pkg::end_cause_type  end_cause;

   modport source (output valid, output single_devices, output second_devices,
                   output end_cause, input ready);
   modport sink   (input valid, input single_devices, input second_devices,
                   input end_cause, output ready);
endinterface

// ===== hw/rtl/vgm_command_device_scanner.sv =====
// Command stream device scanner: opcode decode, operand skip and chip usage masks
// A result appears on rsp in the cycle after the byte that ends the scan is transferred.
// Throughput: one byte per cycle; the parse state is updated in a single pass per transfer.
// A byte is taken whenever the result register is empty or is being drained in the same cycle.
// Reset (synchronous, active high) clears the parse state, the masks, the result valid flag
// and the format version.
module vgm_command_device_scanner (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         csr_write_enable,
   input  logic [vgmscan_pkg::VERSION_WIDTH-1:0]        csr_write_data,
   vgmscan_req_if.sink                                  req_if,
   vgmscan_rsp_if.source                                rsp_if
);

   localparam logic [3:0] PH_OPCODE   = 4'd0;
   localparam logic [3:0] PH_SKIP     = 4'd1;
   localparam logic [3:0] PH_STEREO   = 4'd2;
   localparam logic [3:0] PH_PARAM    = 4'd3;
   localparam logic [3:0] PH_BLK_PAD  = 4'd4;
   localparam logic [3:0] PH_BLK_TYPE = 4'd5;
   localparam logic [3:0] PH_BLK_SIZE = 4'd6;
   localparam logic [3:0] PH_RAM_PAD  = 4'd7;
   localparam logic [3:0] PH_RAM_TYPE = 4'd8;
   localparam logic [3:0] PH_RAM_ADDR = 4'd9;
   localparam logic [3:0] PH_RAM_SIZE = 4'd10;

   localparam int unsigned SKIP_WIDTH = 31;
   localparam logic [SKIP_WIDTH-1:0] RAM_ADDR_BYTES = SKIP_WIDTH'(6);

   logic [vgmscan_pkg::VERSION_WIDTH-1:0] format_version_ff;

   logic [3:0]                phase_ff, phase_in;
   logic [SKIP_WIDTH-1:0]     skip_ff, skip_in;
   logic [31:0]               size_acc_ff, size_acc_in;
   logic [1:0]                size_idx_ff, size_idx_in;
   vgmscan_pkg::chip_type     pending_chip_ff, pending_chip_in;
   vgmscan_pkg::dev_mask_type single_seen_ff, single_seen_in;
   vgmscan_pkg::dev_mask_type dual_seen_ff, dual_seen_in;
   logic                      finished_ff, finished_in;

   logic                       rsp_valid_ff;
   vgmscan_pkg::dev_mask_type  rsp_single_ff, rsp_dual_ff;
   vgmscan_pkg::end_cause_type rsp_cause_ff;

   logic                       req_transfer;
   logic                       stop;
   logic                       emit;
   vgmscan_pkg::end_cause_type cause;
   vgmscan_pkg::dev_mask_type  res_single, res_dual;
   vgmscan_pkg::op_decode_type dec;
   logic [7:0]                 b;
   logic [31:0]                size_word;
   logic [23:0]                ram_len;
   logic [SKIP_WIDTH-1:0]      skip_dec;
   logic [SKIP_WIDTH-1:0]      size_skip;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_transfer = req_if.valid && req_if.ready;
   assign b            = req_if.data_byte;

   assign dec = vgmscan_pkg::classify(b, format_version_ff >= vgmscan_pkg::LONG_OPS_VERSION);

   assign size_word = size_acc_ff | (32'(b) << {size_idx_ff, 3'b000});
   assign ram_len   = size_word[23:0] - 24'd1;
   assign skip_dec  = (skip_ff != '0) ? skip_ff - SKIP_WIDTH'(1) : skip_ff;
   assign size_skip = (phase_ff == PH_BLK_SIZE) ? size_word[SKIP_WIDTH-1:0]
                                                : SKIP_WIDTH'(ram_len);

   always_comb begin
      phase_in        = phase_ff;
      skip_in         = skip_ff;
      size_acc_in     = size_acc_ff;
      size_idx_in     = size_idx_ff;
      pending_chip_in = pending_chip_ff;
      single_seen_in  = single_seen_ff;
      dual_seen_in    = dual_seen_ff;
      finished_in     = finished_ff;
      stop            = 1'b0;
      cause           = vgmscan_pkg::CAUSE_RAN_OUT;
      emit            = 1'b0;

      if (req_transfer && !finished_ff) begin
         case (phase_ff)
            PH_OPCODE: begin
               skip_in = SKIP_WIDTH'(dec.len);
               case (dec.kind)
                  vgmscan_pkg::KIND_END: begin
                     stop  = 1'b1;
                     cause = vgmscan_pkg::CAUSE_END_OPCODE;
                  end
                  vgmscan_pkg::KIND_UNKNOWN: begin
                     stop  = 1'b1;
                     cause = vgmscan_pkg::CAUSE_UNKNOWN_OP;
                  end
                  vgmscan_pkg::KIND_PLAIN: begin
                     single_seen_in = single_seen_ff | vgmscan_pkg::chip_bit(dec.chip);
                     phase_in = (dec.len != '0) ? PH_SKIP : PH_OPCODE;
                  end
                  vgmscan_pkg::KIND_DUALCHIP: begin
                     dual_seen_in = dual_seen_ff | vgmscan_pkg::chip_bit(dec.chip);
                     phase_in = (dec.len != '0) ? PH_SKIP : PH_OPCODE;
                  end
                  vgmscan_pkg::KIND_PARAM: begin
                     pending_chip_in = dec.chip;
                     skip_in  = SKIP_WIDTH'(dec.len) - SKIP_WIDTH'(1);
                     phase_in = PH_PARAM;
                  end
                  vgmscan_pkg::KIND_STEREO: phase_in = PH_STEREO;
                  vgmscan_pkg::KIND_BLOCK:  phase_in = PH_BLK_PAD;
                  default:                  phase_in = PH_RAM_PAD;
               endcase
            end
            PH_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  phase_in = PH_OPCODE;
               end
            end
            PH_RAM_ADDR: begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  phase_in = PH_RAM_SIZE;
               end
            end
            PH_STEREO: begin
               if (b != vgmscan_pkg::STEREO_OFF) begin
                  single_seen_in = single_seen_ff |
                                   vgmscan_pkg::chip_bit(vgmscan_pkg::chip_type'(
                                                         vgmscan_pkg::MAX_CHIP));
               end
               phase_in = PH_OPCODE;
            end
            PH_PARAM: begin
               // top bit of the first operand selects the second instance
               if (b[7]) begin
                  dual_seen_in = dual_seen_ff | vgmscan_pkg::chip_bit(pending_chip_ff);
               end else begin
                  single_seen_in = single_seen_ff | vgmscan_pkg::chip_bit(pending_chip_ff);
               end
               phase_in = (skip_ff != '0) ? PH_SKIP : PH_OPCODE;
            end
            PH_BLK_PAD: phase_in = PH_BLK_TYPE;
            PH_RAM_PAD: phase_in = PH_RAM_TYPE;
            PH_BLK_TYPE, PH_RAM_TYPE: begin
               single_seen_in = single_seen_ff |
                                vgmscan_pkg::chip_bit(vgmscan_pkg::block_chip(b));
               size_acc_in = '0;
               size_idx_in = '0;
               if (phase_ff == PH_BLK_TYPE) begin
                  phase_in = PH_BLK_SIZE;
               end else begin
                  skip_in  = RAM_ADDR_BYTES;
                  phase_in = PH_RAM_ADDR;
               end
            end
            PH_BLK_SIZE, PH_RAM_SIZE: begin
               size_acc_in = size_word;
               size_idx_in = size_idx_ff + 2'd1;
               if (size_idx_ff == 2'd3) begin
                  skip_in  = size_skip;
                  phase_in = (size_skip != '0) ? PH_SKIP : PH_OPCODE;
               end
            end
            default: phase_in = PH_OPCODE;
         endcase

         if (req_if.last_byte) begin
            stop = 1'b1;
         end
         if (stop) begin
            emit        = 1'b1;
            finished_in = 1'b1;
         end
      end

      res_single = single_seen_in;
      res_dual   = dual_seen_in;

      if (req_transfer && req_if.last_byte) begin
         phase_in        = PH_OPCODE;
         skip_in         = '0;
         size_acc_in     = '0;
         size_idx_in     = '0;
         pending_chip_in = '0;
         single_seen_in  = '0;
         dual_seen_in    = '0;
         finished_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         format_version_ff <= '0;
      end else if (csr_write_enable) begin
         format_version_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_OPCODE;
         skip_ff         <= '0;
         size_acc_ff     <= '0;
         size_idx_ff     <= '0;
         pending_chip_ff <= '0;
         single_seen_ff  <= '0;
         dual_seen_ff    <= '0;
         finished_ff     <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         skip_ff         <= skip_in;
         size_acc_ff     <= size_acc_in;
         size_idx_ff     <= size_idx_in;
         pending_chip_ff <= pending_chip_in;
         single_seen_ff  <= single_seen_in;
         dual_seen_ff    <= dual_seen_in;
         finished_ff     <= finished_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_single_ff <= res_single;
         rsp_dual_ff   <= res_dual;
         rsp_cause_ff  <= cause;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.single_devices = rsp_single_ff;
   assign rsp_if.second_devices = rsp_dual_ff;
   assign rsp_if.end_cause      = rsp_cause_ff;

endmodule

// ===== hw/rtl/vgmscan_checker.sv =====
// Port-level checker for the command stream device scanner, bound to the scanner module
module vgmscan_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_ready,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  vgmscan_pkg::dev_mask_type   single_devices,
   input  vgmscan_pkg::dev_mask_type   second_devices,
   input  vgmscan_pkg::end_cause_type  end_cause
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(single_devices) &&
                                  $stable(second_devices) && $stable(end_cause))
      else $error("stalled result changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an empty result register must never stall the byte stream
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (end_cause == vgmscan_pkg::CAUSE_END_OPCODE ||
                     end_cause == vgmscan_pkg::CAUSE_UNKNOWN_OP ||
                     end_cause == vgmscan_pkg::CAUSE_RAN_OUT))
      else $error("bad end cause");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !single_devices[0] && !second_devices[0])
      else $error("chip zero flagged");

endmodule

bind vgm_command_device_scanner vgmscan_checker u_vgmscan_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .single_devices (rsp_if.single_devices),
   .second_devices (rsp_if.second_devices),
   .end_cause      (rsp_if.end_cause)
);
